// File: rtl/core/lsr_pkg.sv
// Package: shared widths, register codes and payload types of the slope reconstruction block.
package lsr_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int FRACTION_BITS = 16;

    // Slope magnitudes never exceed the largest positive value.
    localparam int MAG_BITS  = VALUE_BITS - 1;
    // Van Albada operands are brought below 2^31 before the products.
    localparam int ALB_BITS  = 31;
    localparam int NRM_BITS  = (MAG_BITS > ALB_BITS) ? MAG_BITS : ALB_BITS;

    // Shared shift-add multiplier.
    localparam int MULX_BITS = (2 * ALB_BITS > VALUE_BITS) ? 2 * ALB_BITS : VALUE_BITS;
    localparam int MULY_BITS = (ALB_BITS + 2 > VALUE_BITS) ? ALB_BITS + 2 : VALUE_BITS;
    localparam int PROD_BITS = MULX_BITS + MULY_BITS;

    // Shared restoring divider.
    localparam int DIVN_BITS = (2 * VALUE_BITS > 3 * ALB_BITS + 1) ? 2 * VALUE_BITS
                                                                  : 3 * ALB_BITS + 1;
    localparam int DIVD_BITS = (VALUE_BITS > 2 * ALB_BITS + 1) ? VALUE_BITS : 2 * ALB_BITS + 1;

    localparam logic [MAG_BITS-1:0] SLOPE_MAX = '1;

    localparam int THETA_BITS = 15;
    localparam int THETA_FRAC = 12;
    localparam logic [THETA_BITS-1:0] THETA_RESET = 15'd4096;

    localparam int MODE_BITS = 2;
    localparam logic [MODE_BITS-1:0] MODE_MINMOD    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_KURGANOV  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_VAN_LEER  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_VAN_ALBADA = 2'd3;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = THETA_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMITER_MODE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THETA_GAIN   = 1'b1;

    localparam int JOBQ_DEPTH_LOG2 = 1;
    localparam int RESQ_DEPTH_LOG2 = 1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] cell_value;
        logic signed [VALUE_BITS-1:0] cell_center;
        logic signed [VALUE_BITS-1:0] left_vertex_pos;
        logic signed [VALUE_BITS-1:0] right_vertex_pos;
        logic                         last_cell;
    } t_cell_in;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] left_vertex_value;
        logic signed [VALUE_BITS-1:0] right_vertex_value;
        logic                         last_result;
    } t_cell_out;

    // One classified cell, with the window it saw.
    typedef struct packed {
        logic [1:0]                   seen;
        logic                         last;
        logic signed [VALUE_BITS-1:0] v;
        logic signed [VALUE_BITS-1:0] x;
        logic signed [VALUE_BITS-1:0] pl;
        logic signed [VALUE_BITS-1:0] pr;
        logic signed [VALUE_BITS-1:0] nv;
        logic signed [VALUE_BITS-1:0] nx;
        logic signed [VALUE_BITS-1:0] npl;
        logic signed [VALUE_BITS-1:0] npr;
        logic signed [VALUE_BITS-1:0] ov;
        logic signed [VALUE_BITS-1:0] ox;
    } t_job;

    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] mag;
    } t_smag;

endpackage

// File: rtl/core/lsr_fifo.sv
// Small show-ahead queue built from registers.
module lsr_fifo #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr;
    logic [DEPTH_LOG2-1:0] r_rd;
    logic [DEPTH_LOG2:0]   r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == (DEPTH_LOG2 + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/core/lsr_front.sv
// Front end: three-cell window that classifies each cell into a job.
module lsr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  lsr_pkg::t_cell_in i_cell,
    output lsr_pkg::t_job    o_job,
    output logic             o_job_valid
);
    logic [1:0]                           r_seen;
    logic signed [lsr_pkg::VALUE_BITS-1:0] r_ov, r_ox, r_nv, r_nx, r_npl, r_npr;

    always_comb begin
        o_job.seen = r_seen;
        o_job.last = i_cell.last_cell;
        o_job.v    = i_cell.cell_value;
        o_job.x    = i_cell.cell_center;
        o_job.pl   = i_cell.left_vertex_pos;
        o_job.pr   = i_cell.right_vertex_pos;
        o_job.nv   = r_nv;
        o_job.nx   = r_nx;
        o_job.npl  = r_npl;
        o_job.npr  = r_npr;
        o_job.ov   = r_ov;
        o_job.ox   = r_ox;
    end

    // A first cell that is not also the last gives nothing yet.
    assign o_job_valid = i_accept && (r_seen != 2'd0 || i_cell.last_cell);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
            r_ov   <= '0;
            r_ox   <= '0;
            r_nv   <= '0;
            r_nx   <= '0;
            r_npl  <= '0;
            r_npr  <= '0;
        end else if (i_accept) begin
            if (i_cell.last_cell) begin
                r_seen <= 2'd0;
            end else begin
                r_ov   <= r_nv;
                r_ox   <= r_nx;
                r_nv   <= i_cell.cell_value;
                r_nx   <= i_cell.cell_center;
                r_npl  <= i_cell.left_vertex_pos;
                r_npr  <= i_cell.right_vertex_pos;
                r_seen <= (r_seen == 2'd2) ? 2'd2 : r_seen + 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/lsr_seqmul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module lsr_seqmul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lsr_pkg::MULX_BITS-1:0] i_x,
    input  logic [lsr_pkg::MULY_BITS-1:0] i_y,
    output logic                          o_done,
    output logic [lsr_pkg::PROD_BITS-1:0] o_prod
);
    localparam int CW = $clog2(lsr_pkg::MULY_BITS);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [lsr_pkg::PROD_BITS-1:0] r_acc;
    logic [lsr_pkg::PROD_BITS-1:0] r_xs;
    logic [lsr_pkg::MULY_BITS-1:0] r_ys;

    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(lsr_pkg::MULY_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_xs  <= lsr_pkg::PROD_BITS'(i_x);
            r_ys  <= i_y;
        end else if (r_busy) begin
            if (r_ys[0]) begin
                r_acc <= r_acc + r_xs;
            end
            r_xs <= r_xs << 1;
            r_ys <= r_ys >> 1;
        end
    end

endmodule

// File: rtl/core/lsr_seqdiv.sv
// Restoring divider, one quotient bit per cycle.
module lsr_seqdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lsr_pkg::DIVN_BITS-1:0] i_dividend,
    input  logic [lsr_pkg::DIVD_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [lsr_pkg::DIVN_BITS-1:0] o_quot
);
    localparam int NB = lsr_pkg::DIVN_BITS;
    localparam int DB = lsr_pkg::DIVD_BITS;
    localparam int CW = $clog2(NB);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NB-1:0] r_quo;
    logic [DB:0]   r_rem;
    logic [DB-1:0] r_den;
    logic [DB:0]   rem_sh;
    logic          take;

    assign rem_sh = {r_rem[DB-1:0], r_quo[NB-1]};
    assign take   = (rem_sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NB-2:0], take};
            r_rem <= take ? rem_sh - {1'b0, r_den} : rem_sh;
        end
    end

endmodule

// File: rtl/core/lsr_back.sv
// Back end: slopes, limiter and vertex values through a shared multiplier and divider.
module lsr_back #(
    parameter int FRACTION_BITS = lsr_pkg::FRACTION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lsr_pkg::MODE_BITS-1:0]  i_mode,
    input  logic [lsr_pkg::THETA_BITS-1:0] i_theta,
    input  lsr_pkg::t_job                  i_job,
    input  logic                           i_job_empty,
    output logic                           o_job_pop,
    output lsr_pkg::t_cell_out             o_res,
    output logic                           o_res_push,
    input  logic                           i_res_full
);
    localparam int VB   = lsr_pkg::VALUE_BITS;
    localparam int MB   = lsr_pkg::MAG_BITS;
    localparam int AB   = lsr_pkg::ALB_BITS;
    localparam int NRB  = lsr_pkg::NRM_BITS;
    localparam int PB   = lsr_pkg::PROD_BITS;
    localparam int SATB = (lsr_pkg::DIVN_BITS > PB) ? lsr_pkg::DIVN_BITS : PB;
    localparam int KW   = $clog2(NRB + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SL_GO  = 4'd1;
    localparam logic [3:0] ST_SL_WT  = 4'd2;
    localparam logic [3:0] ST_LIM    = 4'd3;
    localparam logic [3:0] ST_KG_WT  = 4'd4;
    localparam logic [3:0] ST_VL_MW  = 4'd5;
    localparam logic [3:0] ST_VL_DW  = 4'd6;
    localparam logic [3:0] ST_VA_NRM = 4'd7;
    localparam logic [3:0] ST_VA_M1  = 4'd8;
    localparam logic [3:0] ST_VA_M2  = 4'd9;
    localparam logic [3:0] ST_VA_M3  = 4'd10;
    localparam logic [3:0] ST_VA_M4  = 4'd11;
    localparam logic [3:0] ST_VA_DW  = 4'd12;
    localparam logic [3:0] ST_VX_GO  = 4'd13;
    localparam logic [3:0] ST_VX_WT  = 4'd14;
    localparam logic [3:0] ST_PUSH   = 4'd15;

    localparam logic [1:0] SEL_B = 2'd0;
    localparam logic [1:0] SEL_A = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    localparam logic signed [VB:0] VMAX_E = {2'b00, {(VB - 1){1'b1}}};
    localparam logic signed [VB:0] VMIN_E = {2'b11, {(VB - 1){1'b0}}};

    typedef struct packed {
        logic          neg;
        logic [VB-1:0] mag;
    } t_diff;

    function automatic t_diff diff_of(input logic signed [VB-1:0] p,
                                      input logic signed [VB-1:0] q);
        logic signed [VB:0] d;
        t_diff r;
        d     = {p[VB-1], p} - {q[VB-1], q};
        r.neg = d[VB];
        r.mag = d[VB] ? VB'(-d) : d[VB-1:0];
        return r;
    endfunction

    function automatic lsr_pkg::t_smag mk_sat(input logic neg, input logic [SATB-1:0] m);
        lsr_pkg::t_smag r;
        r.mag = (m > SATB'(lsr_pkg::SLOPE_MAX)) ? lsr_pkg::SLOPE_MAX : m[MB-1:0];
        r.neg = neg && (r.mag != '0);
        return r;
    endfunction

    logic [3:0]         r_state;
    logic [1:0]         r_sel;
    lsr_pkg::t_job      r_job;
    lsr_pkg::t_smag     r_a, r_b, r_c, r_phi;
    logic [NRB-1:0]     r_na, r_nb;
    logic [KW-1:0]      r_k;
    logic [PB-1:0]      r_pa, r_sq;
    logic               r_emit, r_side;
    logic signed [VB-1:0] r_lv, r_rv;

    // shared units
    logic                          mul_start, mul_done;
    logic [lsr_pkg::MULX_BITS-1:0] mul_x;
    logic [lsr_pkg::MULY_BITS-1:0] mul_y;
    logic [PB-1:0]                 mul_prod;
    logic                          div_start, div_done;
    logic [lsr_pkg::DIVN_BITS-1:0] div_n, div_q;
    logic [lsr_pkg::DIVD_BITS-1:0] div_d;

    // slope operands
    logic signed [VB-1:0] q1, q0, x1, x0;
    t_diff                sl_dq, sl_dx;
    lsr_pkg::t_smag       sl_val;

    // limiter
    lsr_pkg::t_smag  mm_val, zero_s, kg_val, vl_val, va_val;
    logic            same_nz, kg_ok;
    logic [MB-1:0]   ab_min;
    logic [PB-1:0]   kg_t;
    logic signed [AB+1:0] va_s;
    logic [AB+1:0]   va_sabs;
    logic            va_neg;
    logic [SATB-1:0] va_lim, va_q;

    // vertex
    logic                 use2;
    logic signed [VB-1:0] qc, ctr, pos;
    t_diff                vx_dx;
    logic [PB-1:0]        vx_t;
    logic                 vx_neg, vx_over;
    logic signed [VB:0]   qce, vx_room, vx_sum;
    logic signed [VB-1:0] vx_val;

    lsr_seqmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    lsr_seqdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        case (r_sel)
            SEL_A: begin
                q1 = r_job.nv; q0 = r_job.ov; x1 = r_job.nx; x0 = r_job.ox;
            end
            SEL_C: begin
                q1 = r_job.v;  q0 = r_job.ov; x1 = r_job.x;  x0 = r_job.ox;
            end
            default: begin
                q1 = r_job.v;  q0 = r_job.nv; x1 = r_job.x;  x0 = r_job.nx;
            end
        endcase
        sl_dq = diff_of(q1, q0);
        sl_dx = diff_of(x1, x0);
        // Zero cell spacing: flat when the values agree, else steepest slope.
        if (sl_dx.mag == '0) begin
            sl_val = mk_sat(sl_dq.neg, (sl_dq.mag == '0) ? '0 : SATB'(lsr_pkg::SLOPE_MAX));
        end else begin
            sl_val = mk_sat(sl_dq.neg != sl_dx.neg, SATB'(div_q));
        end
    end

    always_comb begin
        zero_s  = '0;
        same_nz = (r_a.mag != '0) && (r_b.mag != '0) && (r_a.neg == r_b.neg);
        kg_ok   = same_nz && ((r_c.mag == '0) || (r_c.neg == r_a.neg));
        ab_min  = (r_a.mag <= r_b.mag) ? r_a.mag : r_b.mag;
        // minmod: opposite signs flatten, a tie keeps the left slope
        if ((r_a.mag != '0) && (r_b.mag != '0) && (r_a.neg != r_b.neg)) begin
            mm_val = zero_s;
        end else begin
            mm_val = (r_a.mag <= r_b.mag) ? r_a : r_b;
        end
        kg_t = mul_prod >> lsr_pkg::THETA_FRAC;
        kg_val.neg = r_a.neg;
        kg_val.mag = (kg_t > PB'(r_c.mag)) ? r_c.mag : kg_t[MB-1:0];
        vl_val  = mk_sat(r_a.neg, SATB'(div_q));
        va_s    = (r_a.neg ? -$signed({2'b00, r_na[AB-1:0]}) : $signed({2'b00, r_na[AB-1:0]}))
                + (r_b.neg ? -$signed({2'b00, r_nb[AB-1:0]}) : $signed({2'b00, r_nb[AB-1:0]}));
        va_sabs = va_s[AB+1] ? (AB + 2)'(-va_s) : va_s;
        va_neg  = (r_a.neg != r_b.neg) != va_s[AB+1];
        va_lim  = SATB'(lsr_pkg::SLOPE_MAX) >> r_k;
        va_q    = (SATB'(div_q) > va_lim) ? SATB'(lsr_pkg::SLOPE_MAX) : (SATB'(div_q) << r_k);
        va_val  = mk_sat(va_neg, va_q);
    end

    always_comb begin
        use2    = r_emit || (r_job.seen == 2'd0);
        qc      = use2 ? r_job.v : r_job.nv;
        ctr     = use2 ? r_job.x : r_job.nx;
        if (r_side) begin
            pos = use2 ? r_job.pr : r_job.npr;
        end else begin
            pos = use2 ? r_job.pl : r_job.npl;
        end
        vx_dx   = diff_of(pos, ctr);
        vx_t    = mul_prod >> FRACTION_BITS;
        vx_neg  = r_phi.neg != vx_dx.neg;
        qce     = {qc[VB-1], qc};
        vx_room = vx_neg ? qce - VMIN_E : VMAX_E - qce;
        vx_over = vx_t > PB'(vx_room);
        vx_sum  = vx_neg ? qce - $signed({1'b0, vx_t[VB-1:0]})
                         : qce + $signed({1'b0, vx_t[VB-1:0]});
        if (vx_over) begin
            vx_val = vx_neg ? VMIN_E[VB-1:0] : VMAX_E[VB-1:0];
        end else begin
            vx_val = vx_sum[VB-1:0];
        end
    end

    // unit launches
    always_comb begin
        mul_start = 1'b0;
        mul_x     = '0;
        mul_y     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        case (r_state)
            ST_SL_GO: begin
                div_start = (sl_dx.mag != '0);
                div_n     = lsr_pkg::DIVN_BITS'(sl_dq.mag) << FRACTION_BITS;
                div_d     = lsr_pkg::DIVD_BITS'(sl_dx.mag);
            end
            ST_LIM: begin
                if (i_mode == lsr_pkg::MODE_KURGANOV) begin
                    mul_start = kg_ok;
                    mul_x     = lsr_pkg::MULX_BITS'(ab_min);
                    mul_y     = lsr_pkg::MULY_BITS'(i_theta);
                end else if (i_mode == lsr_pkg::MODE_VAN_LEER) begin
                    mul_start = same_nz;
                    mul_x     = lsr_pkg::MULX_BITS'(r_a.mag);
                    mul_y     = lsr_pkg::MULY_BITS'(r_b.mag);
                end
            end
            ST_VL_MW: begin
                div_start = mul_done;
                div_n     = lsr_pkg::DIVN_BITS'(mul_prod) << 1;
                div_d     = lsr_pkg::DIVD_BITS'(r_a.mag) + lsr_pkg::DIVD_BITS'(r_b.mag);
            end
            ST_VA_NRM: begin
                mul_start = ((r_na | r_nb) >> AB) == '0 && ((r_na | r_nb) != '0);
                mul_x     = lsr_pkg::MULX_BITS'(r_na);
                mul_y     = lsr_pkg::MULY_BITS'(r_nb);
            end
            ST_VA_M1: begin
                mul_start = mul_done;
                mul_x     = lsr_pkg::MULX_BITS'(mul_prod);
                mul_y     = lsr_pkg::MULY_BITS'(va_sabs);
            end
            ST_VA_M2: begin
                mul_start = mul_done;
                mul_x     = lsr_pkg::MULX_BITS'(r_na);
                mul_y     = lsr_pkg::MULY_BITS'(r_na);
            end
            ST_VA_M3: begin
                mul_start = mul_done;
                mul_x     = lsr_pkg::MULX_BITS'(r_nb);
                mul_y     = lsr_pkg::MULY_BITS'(r_nb);
            end
            ST_VA_M4: begin
                div_start = mul_done;
                div_n     = lsr_pkg::DIVN_BITS'(r_pa);
                div_d     = lsr_pkg::DIVD_BITS'(r_sq + mul_prod);
            end
            ST_VX_GO: begin
                mul_start = 1'b1;
                mul_x     = lsr_pkg::MULX_BITS'(r_phi.mag);
                mul_y     = lsr_pkg::MULY_BITS'(vx_dx.mag);
            end
            default: begin
            end
        endcase
    end

    assign o_job_pop  = (r_state == ST_IDLE) && !i_job_empty;
    assign o_res_push = (r_state == ST_PUSH);
    assign o_res.left_vertex_value  = r_lv;
    assign o_res.right_vertex_value = r_rv;
    assign o_res.last_result        = use2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= SEL_B;
            r_emit  <= 1'b0;
            r_side  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_emit <= 1'b0;
                        r_side <= 1'b0;
                        r_sel  <= SEL_B;
                        r_state <= (i_job.seen == 2'd0) ? ST_VX_GO : ST_SL_GO;
                    end
                end
                ST_SL_GO, ST_SL_WT: begin
                    if (r_state == ST_SL_GO && sl_dx.mag != '0) begin
                        r_state <= ST_SL_WT;
                    end else if (r_state == ST_SL_GO || div_done) begin
                        case (r_sel)
                            SEL_B: begin
                                if (r_job.seen == 2'd1) begin
                                    r_state <= ST_VX_GO;
                                end else begin
                                    r_sel   <= SEL_A;
                                    r_state <= ST_SL_GO;
                                end
                            end
                            SEL_A: begin
                                if (i_mode == lsr_pkg::MODE_KURGANOV) begin
                                    r_sel   <= SEL_C;
                                    r_state <= ST_SL_GO;
                                end else begin
                                    r_state <= ST_LIM;
                                end
                            end
                            default: begin
                                r_state <= ST_LIM;
                            end
                        endcase
                    end
                end
                ST_LIM: begin
                    case (i_mode)
                        lsr_pkg::MODE_MINMOD: begin
                            r_state <= ST_VX_GO;
                        end
                        lsr_pkg::MODE_KURGANOV: begin
                            r_state <= kg_ok ? ST_KG_WT : ST_VX_GO;
                        end
                        lsr_pkg::MODE_VAN_LEER: begin
                            r_state <= same_nz ? ST_VL_MW : ST_VX_GO;
                        end
                        default: begin
                            r_k     <= '0;
                            r_state <= ST_VA_NRM;
                        end
                    endcase
                end
                ST_KG_WT: begin
                    if (mul_done) begin
                        r_state <= ST_VX_GO;
                    end
                end
                ST_VL_MW: begin
                    if (mul_done) begin
                        r_state <= ST_VL_DW;
                    end
                end
                ST_VL_DW: begin
                    if (div_done) begin
                        r_state <= ST_VX_GO;
                    end
                end
                ST_VA_NRM: begin
                    // Shift both magnitudes until the larger fits the product width.
                    if (((r_na | r_nb) >> AB) != '0) begin
                        r_k <= r_k + 1'b1;
                    end else if ((r_na | r_nb) == '0) begin
                        r_state <= ST_VX_GO;
                    end else begin
                        r_state <= ST_VA_M1;
                    end
                end
                ST_VA_M1: begin
                    if (mul_done) begin
                        r_state <= ST_VA_M2;
                    end
                end
                ST_VA_M2: begin
                    if (mul_done) begin
                        r_state <= ST_VA_M3;
                    end
                end
                ST_VA_M3: begin
                    if (mul_done) begin
                        r_state <= ST_VA_M4;
                    end
                end
                ST_VA_M4: begin
                    if (mul_done) begin
                        r_state <= ST_VA_DW;
                    end
                end
                ST_VA_DW: begin
                    if (div_done) begin
                        r_state <= ST_VX_GO;
                    end
                end
                ST_VX_GO: begin
                    r_state <= ST_VX_WT;
                end
                ST_VX_WT: begin
                    if (mul_done) begin
                        r_side  <= !r_side;
                        r_state <= r_side ? ST_PUSH : ST_VX_GO;
                    end
                end
                ST_PUSH: begin
                    if (!i_res_full) begin
                        if (!r_emit && r_job.seen != 2'd0 && r_job.last) begin
                            r_emit  <= 1'b1;
                            r_state <= ST_VX_GO;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    r_job <= i_job;
                    r_phi <= '0;
                end
            end
            ST_SL_GO, ST_SL_WT: begin
                if ((r_state == ST_SL_GO && sl_dx.mag == '0) || (r_state == ST_SL_WT && div_done)) begin
                    case (r_sel)
                        SEL_B: begin
                            r_b   <= sl_val;
                            r_phi <= sl_val;
                        end
                        SEL_A: begin
                            r_a <= sl_val;
                        end
                        default: begin
                            r_c <= sl_val;
                        end
                    endcase
                end
            end
            ST_LIM: begin
                r_na <= NRB'(r_a.mag);
                r_nb <= NRB'(r_b.mag);
                case (i_mode)
                    lsr_pkg::MODE_MINMOD: r_phi <= mm_val;
                    default:              r_phi <= zero_s;
                endcase
            end
            ST_KG_WT: begin
                if (mul_done) begin
                    r_phi <= kg_val;
                end
            end
            ST_VL_DW: begin
                if (div_done) begin
                    r_phi <= vl_val;
                end
            end
            ST_VA_NRM: begin
                if (((r_na | r_nb) >> AB) != '0) begin
                    r_na <= r_na >> 1;
                    r_nb <= r_nb >> 1;
                end
            end
            ST_VA_M2: begin
                if (mul_done) begin
                    r_pa <= mul_prod;
                end
            end
            ST_VA_M3: begin
                if (mul_done) begin
                    r_sq <= mul_prod;
                end
            end
            ST_VA_DW: begin
                if (div_done) begin
                    r_phi <= va_val;
                end
            end
            ST_VX_WT: begin
                if (mul_done) begin
                    if (r_side) begin
                        r_rv <= vx_val;
                    end else begin
                        r_lv <= vx_val;
                    end
                end
            end
            ST_PUSH: begin
                // The last cell of a row reuses the one-sided slope.
                if (!i_res_full && !r_emit && r_job.seen != 2'd0 && r_job.last) begin
                    r_phi <= r_b;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/limited_slope_reconstruction_1d.sv
// Top level: limited-slope (MUSCL) vertex reconstruction of a stream of 1D cells.
//
// Input channel: write a cell on i_cell with push while full is low; one transfer per
// edge where push is high and full is low. Result channel: while empty is low the
// oldest result sits on o_result; pop takes it on an edge where pop is high.
// Results run one cell behind: the first cell of a row gives nothing, each later cell
// gives the previous cell's vertex values, and the last cell gives two results (the
// last one marked by last_result). A single-cell row gives one flat result.
// Configuration: i_cfg_we writes register i_cfg_idx (0 limiter mode, 1 theta gain)
// at the edge; write only while no cell is in flight.
// The back end takes one cell at a time, the least work for a single-cell row and the
// most for the last cell of a row under van Albada. The cost is set by the shared
// bit-serial divider (used for each slope and quotient) and the shift-add multiplier
// (two products per result). Van Albada is the slowest mode.
// A two-entry job queue lets the window accept cells while the back end works.
// Stall: when the result queue fills, the back end holds its result and the job
// queue fills up behind it, which raises full.
// Reset (synchronous, i_rst_n low) empties both queues, restarts the row and
// restores limiter mode 0 and theta gain 1.0.
module limited_slope_reconstruction_1d #(
    parameter int FRACTION_BITS = lsr_pkg::FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  lsr_pkg::t_cell_in                 i_cell,
    input  logic                              pop,
    output logic                              empty,
    output lsr_pkg::t_cell_out                o_result,
    input  logic                              i_cfg_we,
    input  logic [lsr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lsr_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    logic [lsr_pkg::MODE_BITS-1:0]  r_limiter_mode;
    logic [lsr_pkg::THETA_BITS-1:0] r_theta_gain;

    logic               accept;
    lsr_pkg::t_job      job_in, job_out;
    logic               job_valid, job_empty, job_pop;
    lsr_pkg::t_cell_out res_in;
    logic               res_push, res_full;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limiter_mode <= lsr_pkg::MODE_MINMOD;
            r_theta_gain   <= lsr_pkg::THETA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsr_pkg::CFG_LIMITER_MODE: r_limiter_mode <= i_cfg_data[lsr_pkg::MODE_BITS-1:0];
                lsr_pkg::CFG_THETA_GAIN:   r_theta_gain   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Classify the cell against the window.
    lsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cell      (i_cell),
        .o_job       (job_in),
        .o_job_valid (job_valid)
    );

    // Hold jobs so the window keeps taking cells.
    lsr_fifo #(
        .WIDTH      ($bits(lsr_pkg::t_job)),
        .DEPTH_LOG2 (lsr_pkg::JOBQ_DEPTH_LOG2)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    lsr_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_limiter_mode),
        .i_theta     (r_theta_gain),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // Results wait here until popped.
    lsr_fifo #(
        .WIDTH      ($bits(lsr_pkg::t_cell_out)),
        .DEPTH_LOG2 (lsr_pkg::RESQ_DEPTH_LOG2)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// File: rtl/core/lsr_checker.sv
// Port checker for the slope reconstruction block, bound to the top level.
module lsr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input lsr_pkg::t_cell_out o_result
);
    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset leaves room for a cell
    a_reset_room: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed before transfer");

    // a result never shows in the cycle right after reset
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result appeared right after reset");

endmodule

bind limited_slope_reconstruction_1d lsr_checker u_lsr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);

// File: tb/tb_top.sv
// Testbench for limited_slope_reconstruction_1d: streams rows of cells and checks vertex values.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Quiet time once the result queue drains, well above the longest back-end pass,
    // so configuration never changes under a cell in flight.
    localparam int SETTLE_CYCLES = 1500;
    // Cycles without any transfer before the run is declared hung.
    localparam int HANG_LIMIT    = 20000;
    localparam bit [63:0] SLOPE_SAT = 64'h7FFF_FFFF;
    localparam longint VAL_HI = 64'sh7FFF_FFFF;
    localparam longint VAL_LO = -64'sh8000_0000;

    typedef struct {
        bit        neg;
        bit [63:0] mag;
    } t_slope;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    lsr_pkg::t_cell_in  i_cell = '0;
    logic               pop = 1'b0;
    logic               empty;
    lsr_pkg::t_cell_out o_result;
    logic               i_cfg_we = 1'b0;
    logic [lsr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx = lsr_pkg::CFG_LIMITER_MODE;
    logic [lsr_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // Predictor copy of the configuration and the three-cell window.
    logic [lsr_pkg::MODE_BITS-1:0]  mdl_mode;
    logic [lsr_pkg::THETA_BITS-1:0] mdl_theta;
    longint mdl_old_v, mdl_new_v, mdl_old_x, mdl_new_x, mdl_pend_l, mdl_pend_r;
    int     mdl_seen;

    lsr_pkg::t_cell_out vertex_values_due[$];
    int  error_count = 0;
    int  cells_sent = 0;
    int  results_checked = 0;
    int  idle_cycles = 0;
    int  pop_hold = 0;
    bit  no_idle = 1'b0;
    longint row_center;
    longint row_value;

    always #1 i_clk = ~i_clk;

    limited_slope_reconstruction_1d i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cell     (i_cell),
        .pop        (pop),
        .empty      (empty),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ---------------------------------------------------------------- predictor

    function automatic t_slope clamp_slope(bit neg, bit [63:0] mag);
        t_slope r;
        r.mag = (mag > SLOPE_SAT) ? SLOPE_SAT : mag;
        r.neg = neg && (r.mag != 0);
        return r;
    endfunction

    function automatic int sign_of(t_slope s);
        return (s.mag == 0) ? 0 : (s.neg ? -1 : 1);
    endfunction

    // Unsigned quotient, saturating to all ones when it does not fit in 64 bits.
    function automatic bit [63:0] quotient_sat(bit [127:0] n, bit [63:0] d);
        bit [127:0] q;
        if (n[127:64] >= d) return '1;
        q = n / {64'd0, d};
        return q[63:0];
    endfunction

    function automatic bit [63:0] shift_sat(bit [127:0] p, int s);
        bit [127:0] t;
        t = p >> s;
        return (t[127:64] != 0) ? '1 : t[63:0];
    endfunction

    function automatic t_slope slope_between(longint q1, longint q0, longint x1, longint x0);
        bit        nq, nx;
        bit [63:0] dq, dx;
        nq = q1 < q0;
        nx = x1 < x0;
        dq = nq ? q0 - q1 : q1 - q0;
        dx = nx ? x0 - x1 : x1 - x0;
        if (dx == 0) return clamp_slope(nq, (dq == 0) ? 64'd0 : SLOPE_SAT);
        return clamp_slope(nq != nx,
                           quotient_sat({64'd0, dq} << lsr_pkg::FRACTION_BITS, dx));
    endfunction

    function automatic t_slope limit_slope(t_slope a, t_slope b, t_slope c);
        bit [63:0]  m, a2, b2, q, t;
        bit [127:0] p;
        longint     s;
        int         k;
        case (mdl_mode)
            lsr_pkg::MODE_MINMOD: begin
                if (sign_of(a) * sign_of(b) < 0) return clamp_slope(1'b0, 0);
                return (a.mag <= b.mag) ? a : b;   // a tie keeps the left slope
            end
            lsr_pkg::MODE_KURGANOV: begin
                if (!(sign_of(a) * sign_of(b) > 0 && sign_of(a) * sign_of(c) >= 0))
                    return clamp_slope(1'b0, 0);
                p = {113'd0, mdl_theta} * {64'd0, (a.mag < b.mag) ? a.mag : b.mag};
                t = shift_sat(p, lsr_pkg::THETA_FRAC);
                if (t > c.mag) t = c.mag;
                return clamp_slope(a.neg, t);
            end
            lsr_pkg::MODE_VAN_LEER: begin
                if (sign_of(a) * sign_of(b) <= 0) return clamp_slope(1'b0, 0);
                p = ({64'd0, a.mag} * {64'd0, b.mag}) << 1;
                return clamp_slope(a.neg, quotient_sat(p, a.mag + b.mag));
            end
            default: begin
                m = (a.mag > b.mag) ? a.mag : b.mag;
                k = 0;
                while ((m >> k) >= 64'h8000_0000) k++;
                a2 = a.mag >> k;
                b2 = b.mag >> k;
                if (a2 == 0 && b2 == 0) return clamp_slope(1'b0, 0);
                s = (a.neg ? -longint'(a2) : longint'(a2)) + (b.neg ? -longint'(b2) : longint'(b2));
                p = {64'd0, a2 * b2} * {64'd0, (s < 0) ? 64'(-s) : 64'(s)};
                q = quotient_sat(p, a2 * a2 + b2 * b2);
                if (k > 0) q = (q > (SLOPE_SAT >> k)) ? SLOPE_SAT : (q << k);
                return clamp_slope((a.neg != b.neg) != (s < 0), q);
            end
        endcase
    endfunction

    function automatic logic signed [lsr_pkg::VALUE_BITS-1:0] vertex_at(longint qc,
                                                                        t_slope phi,
                                                                        longint pos,
                                                                        longint ctr);
        bit        nx, neg;
        bit [63:0] dx, t, room;
        nx = pos < ctr;
        dx = nx ? ctr - pos : pos - ctr;
        t = shift_sat({64'd0, phi.mag} * {64'd0, dx}, lsr_pkg::FRACTION_BITS);
        neg = phi.neg != nx;
        if (!neg) begin
            room = VAL_HI - qc;
            return (t > room) ? VAL_HI[31:0] : 32'(qc + longint'(t));
        end
        room = qc - VAL_LO;
        return (t > room) ? VAL_LO[31:0] : 32'(qc - longint'(t));
    endfunction

    function automatic void queue_result(longint qc, longint ctr, longint pl, longint pr,
                                         t_slope phi, bit last);
        lsr_pkg::t_cell_out r;
        r.left_vertex_value  = vertex_at(qc, phi, pl, ctr);
        r.right_vertex_value = vertex_at(qc, phi, pr, ctr);
        r.last_result        = last;
        vertex_values_due.push_back(r);
    endfunction

    // Advance the window by one cell and queue the vertex values it releases.
    function automatic void reconstruct_cell(lsr_pkg::t_cell_in c);
        longint v, x, pl, pr;
        t_slope phi, b;
        v  = longint'(c.cell_value);
        x  = longint'(c.cell_center);
        pl = longint'(c.left_vertex_pos);
        pr = longint'(c.right_vertex_pos);
        if (mdl_seen == 0) begin
            if (c.last_cell) begin
                queue_result(v, x, pl, pr, clamp_slope(1'b0, 0), 1'b1);
                return;
            end
        end else begin
            b = slope_between(v, mdl_new_v, x, mdl_new_x);
            if (mdl_seen == 1) phi = b;
            else phi = limit_slope(slope_between(mdl_new_v, mdl_old_v, mdl_new_x, mdl_old_x), b,
                                   slope_between(v, mdl_old_v, x, mdl_old_x));
            queue_result(mdl_new_v, mdl_new_x, mdl_pend_l, mdl_pend_r, phi, 1'b0);
            if (c.last_cell) begin
                queue_result(v, x, pl, pr, b, 1'b1);
                mdl_seen = 0;
                return;
            end
        end
        mdl_old_v  = mdl_new_v;
        mdl_old_x  = mdl_new_x;
        mdl_new_v  = v;
        mdl_new_x  = x;
        mdl_pend_l = pl;
        mdl_pend_r = pr;
        mdl_seen   = (mdl_seen >= 2) ? 2 : mdl_seen + 1;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_cell(lsr_pkg::t_cell_in c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) @(negedge i_clk);
        reconstruct_cell(c);
        i_cell = c;
        push   = 1'b1;
        // Hold the cell until the transfer happens.
        do @(posedge i_clk); while (full);
        cells_sent++;
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic write_reg(logic [lsr_pkg::CFG_IDX_BITS-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value[lsr_pkg::CFG_DATA_BITS-1:0];
        if (idx == lsr_pkg::CFG_LIMITER_MODE) mdl_mode = value[lsr_pkg::MODE_BITS-1:0];
        else mdl_theta = value[lsr_pkg::THETA_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Wait until every queued result has been taken and the back end has gone quiet.
    task automatic drain_block();
        while (vertex_values_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic lsr_pkg::t_cell_in make_cell(logic signed [31:0] v,
                                                    logic signed [31:0] x,
                                                    logic signed [31:0] pl,
                                                    logic signed [31:0] pr,
                                                    bit last);
        lsr_pkg::t_cell_in c;
        c.cell_value = v;
        c.cell_center = x;
        c.left_vertex_pos = pl;
        c.right_vertex_pos = pr;
        c.last_cell = last;
        return c;
    endfunction

    // One random cell: mostly a smooth mesh with random content, sometimes raw noise
    // or a zero-width spacing.
    function automatic lsr_pkg::t_cell_in random_cell(bit last);
        int     pick;
        longint half;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return make_cell($urandom, $urandom, $urandom, $urandom, last);
        if (pick != 1) row_center += $urandom_range(1, 32'h0004_0000);
        half = $urandom_range(0, 32'h0002_0000);
        case ($urandom_range(0, 2))
            0: row_value += longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000;
            1: row_value = row_value;  // flat run: slopes of zero
            default: row_value = longint'(signed'($urandom));
        endcase
        return make_cell(32'(row_value), 32'(row_center), 32'(row_center - half),
                         32'(row_center + half), last);
    endfunction

    task automatic send_rows(int n_cells);
        int n, len;
        n = 0;
        while (n < n_cells) begin
            len = $urandom_range(1, 8);
            row_center = longint'(signed'(32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000));
            row_value  = longint'(signed'(32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000));
            for (int i = 0; i < len; i++) send_cell(random_cell(i == len - 1));
            n += len;
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Extremes, single and two cell rows, zero-width spacing and minmod ties.
    task automatic test_directed();
        send_cell(make_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        send_cell(make_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_cell(make_cell(32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        send_cell(make_cell(32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        send_cell(make_cell(32'h0003_0000, 32'h0002_0000, 32'h0001_8000, 32'h0002_8000, 1'b0));
        send_cell(make_cell(32'h0003_0000, 32'h0002_0000, 32'h0001_8000, 32'h0002_8000, 1'b1));
        // Equal slopes on both sides: a tie.
        for (int i = 0; i < 4; i++)
            send_cell(make_cell(32'(i * 32'h0002_0000), 32'(i * 32'h0001_0000),
                                32'(i * 32'h0001_0000 - 32'h8000),
                                32'(i * 32'h0001_0000 + 32'h8000), i == 3));
        // A peak: slopes of opposite sign.
        send_cell(make_cell(32'h0000_0000, 32'h0000_0000, 32'hFFFF_8000, 32'h0000_8000, 1'b0));
        send_cell(make_cell(32'h0005_0000, 32'h0001_0000, 32'h0000_8000, 32'h0001_8000, 1'b0));
        send_cell(make_cell(32'h0000_0000, 32'h0002_0000, 32'h0001_8000, 32'h0002_8000, 1'b0));
        send_cell(make_cell(32'hFFFF_0000, 32'h0003_0000, 32'h0002_8000, 32'h0003_8000, 1'b1));
        // Steep data near full scale.
        send_cell(make_cell(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 1'b0));
        send_cell(make_cell(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0));
        send_cell(make_cell(32'h7FFF_FFFF, 32'h0000_0002, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        drain_block();
    endtask

    task automatic test_limiter(int mode, int theta, int n_cells);
        write_reg(lsr_pkg::CFG_LIMITER_MODE, mode);
        write_reg(lsr_pkg::CFG_THETA_GAIN, theta);
        no_idle = ($urandom_range(0, 3) == 0);
        send_rows(n_cells);
        drain_block();
    endtask

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin
        lsr_pkg::t_cell_out want;
        if (i_rst_n && pop && !empty) begin
            if (vertex_values_due.size() == 0) begin
                $error("unexpected result: left %0d right %0d",
                       o_result.left_vertex_value, o_result.right_vertex_value);
                error_count++;
            end else begin
                want = vertex_values_due.pop_front();
                if (o_result.left_vertex_value !== want.left_vertex_value) begin
                    $error("left_vertex_value: expected %0d, got %0d",
                           want.left_vertex_value, o_result.left_vertex_value);
                    error_count++;
                end
                if (o_result.right_vertex_value !== want.right_vertex_value) begin
                    $error("right_vertex_value: expected %0d, got %0d",
                           want.right_vertex_value, o_result.right_vertex_value);
                    error_count++;
                end
                if (o_result.last_result !== want.last_result) begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, o_result.last_result);
                    error_count++;
                end
            end
            results_checked++;
            pop_hold = no_idle ? 0 : $urandom_range(0, 3);
        end
    end

    // Drop pop for the drawn number of cycles after each transfer.
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop = 1'b0;
            pop_hold = pop_hold - 1;
        end else begin
            pop = 1'b1;
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        mdl_mode   = lsr_pkg::MODE_MINMOD;
        mdl_theta  = lsr_pkg::THETA_RESET;
        mdl_old_v  = 0; mdl_new_v = 0; mdl_old_x = 0; mdl_new_x = 0;
        mdl_pend_l = 0; mdl_pend_r = 0;
        mdl_seen   = 0;
        row_center = 0;
        row_value  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_limiter(lsr_pkg::MODE_MINMOD,     32767, 110);
        test_limiter(lsr_pkg::MODE_KURGANOV,    4096, 120);
        test_limiter(lsr_pkg::MODE_KURGANOV,       0, 100);
        test_limiter(lsr_pkg::MODE_KURGANOV,   32767, 120);
        test_limiter(lsr_pkg::MODE_VAN_LEER,    8192, 120);
        test_limiter(lsr_pkg::MODE_VAN_ALBADA,  2048, 120);
        test_limiter(lsr_pkg::MODE_MINMOD,      4096, 100);
        test_limiter(lsr_pkg::MODE_VAN_ALBADA, 12345, 60);

        $display("Sent %0d cells through all four limiters, checked %0d results.",
                 cells_sent, results_checked);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
